// ===== rtl/apeq_pkg.sv =====
// Package for the allpass peak equalizer: widths, fixed-point helpers,
// register indexes and the controller-to-datapath command struct.
// No dependencies.
package apeq_pkg;

    localparam int DATA_W        = 32;
    localparam int SUM_W         = DATA_W + 2;        // exact three-term sums
    localparam int PROD_W        = 2 * DATA_W;
    localparam int PRODUCT_SHIFT = 4;
    localparam int MQ_SHIFT      = DATA_W - 1 - PRODUCT_SHIFT;
    localparam int CFG_IDX_W     = 2;

    // Fixed-point one, 2^(31-PRODUCT_SHIFT)
    localparam logic signed [SUM_W-1:0] UNITY = SUM_W'(1) << MQ_SHIFT;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_GM1 = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        MUL_C_W2,
        MUL_D_OMC,
        MUL_K_W1,
        MUL_C_NEGW,
        MUL_H0_DIFF
    } mul_sel_t;

    typedef enum logic [2:0] {
        MQ_NONE,
        MQ_T2,
        MQ_K,
        MQ_T1,
        MQ_M,
        MQ_H
    } mq_dst_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_OMC,
        ALU_W,
        ALU_A,
        ALU_DIFF
    } alu_op_t;

    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        mul_sel_t mul_sel;
        mq_dst_t  mq_dst;
        alu_op_t  alu_op;
        logic     commit;
    } cmd_t;

    // Saturate an exact sum to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}})
            r = v[DATA_W-1:0];
        else
            r = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    // Scale a full product back to Q format (floor shift) and saturate
    function automatic logic signed [DATA_W-1:0] mulq_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [DATA_W-1:0] r;
        s = p >>> MQ_SHIFT;
        if (s[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){s[PROD_W-1]}})
            r = s[DATA_W-1:0];
        else
            r = s[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [DATA_W-1:0] v);
        return SUM_W'(v);
    endfunction

endpackage

// ===== rtl/allpass_peak_eq_filter.sv =====
// Top level of the allpass peak equalizer section.
// Instantiates apeq_ctrl and apeq_datapath; depends on apeq_pkg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one 32-bit signed sample per transaction.
//   m_tvalid/m_tready/m_tdata return one 32-bit signed equalized sample for
//   each input, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the coefficients:
//   index 0 = c, 1 = d, 2 = H0 (peak gain minus one); index 3 is ignored.
//   cfg_ready is always high; write only while no sample is in flight.
// Timing:
//   One sample occupies the block from the accept cycle through the
//   sequencer steps, whose number is set by the five products that share
//   one multiplier, each followed by a step to scale and saturate it.
//   The result is registered on m_tdata when the last step commits it.
//   A new sample is taken in the cycle after the previous result is
//   registered, so a sample is only taken once the previous one is done.
// Reset clears the coefficients, both allpass delays and m_tvalid.
// Stall: a result waits in the output register while the next sample is
// processed; if that sample finishes first, the sequencer holds it in its
// last step until m_tready drains the output register.
module allpass_peak_eq_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] sample_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import apeq_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    apeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    apeq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (s_tdata),
        .cfg_wr     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (m_tdata)
    );

endmodule

// ===== rtl/apeq_ctrl.sv =====
// Sequencer for the allpass peak equalizer: steps one sample through the
// shared multiplier and adder, and owns the input/output handshakes.
// Depends on apeq_pkg.
module apeq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output apeq_pkg::cmd_t  cmd
);
    import apeq_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_PRE  = 14'b00000000000010,
        S_K    = 14'b00000000000100,
        S_KQ   = 14'b00000000001000,
        S_T1   = 14'b00000000010000,
        S_T1Q  = 14'b00000000100000,
        S_W    = 14'b00000001000000,
        S_M    = 14'b00000010000000,
        S_MQ   = 14'b00000100000000,
        S_A    = 14'b00001000000000,
        S_DIFF = 14'b00010000000000,
        S_H    = 14'b00100000000000,
        S_HQ   = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    // Result may be written only when the output register is free or draining
    assign commit   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_C_W2;
        cmd.mq_dst     = MQ_NONE;
        cmd.alu_op     = ALU_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_x = s_tvalid;
                if (s_tvalid)
                    state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.alu_op  = ALU_OMC;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C_W2;
                state_next  = S_K;
            end
            S_K:
            begin
                cmd.mq_dst  = MQ_T2;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D_OMC;
                state_next  = S_KQ;
            end
            S_KQ:
            begin
                cmd.mq_dst = MQ_K;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_K_W1;
                state_next  = S_T1Q;
            end
            S_T1Q:
            begin
                cmd.mq_dst = MQ_T1;
                state_next = S_W;
            end
            S_W:
            begin
                cmd.alu_op = ALU_W;
                state_next = S_M;
            end
            S_M:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C_NEGW;
                state_next  = S_MQ;
            end
            S_MQ:
            begin
                cmd.mq_dst = MQ_M;
                state_next = S_A;
            end
            S_A:
            begin
                cmd.alu_op = ALU_A;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.alu_op = ALU_DIFF;
                state_next = S_H;
            end
            S_H:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_H0_DIFF;
                state_next  = S_HQ;
            end
            S_HQ:
            begin
                cmd.mq_dst = MQ_H;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.commit = commit;
                if (commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/apeq_datapath.sv =====
// Datapath of the allpass peak equalizer: coefficient and delay registers,
// one shared 32x32 multiplier with product register, saturating adder.
// Depends on apeq_pkg.
module apeq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  apeq_pkg::cmd_t                    cmd,
    input  logic [apeq_pkg::DATA_W-1:0]       sample_in,
    input  logic                              cfg_wr,
    input  logic [apeq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apeq_pkg::DATA_W-1:0]       cfg_data,
    output logic [apeq_pkg::DATA_W-1:0]       sample_out
);
    import apeq_pkg::*;

    // configuration and filter state (reset to zero)
    logic signed [DATA_W-1:0] coef_c_reg, coef_d_reg, peak_gm1_reg;
    logic signed [DATA_W-1:0] w1_reg, w2_reg;

    // per-sample working registers
    logic signed [DATA_W-1:0] x_reg, omc_reg, t2_reg, k_reg, t1_reg, w_reg;
    logic signed [DATA_W-1:0] m_reg, a_reg, diff_reg, h_reg, y_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [DATA_W-1:0] op_a, op_b, neg_w, mq, alu_res, y_next;
    logic signed [PROD_W-1:0] prod_next;

    assign mq        = mulq_sat(prod_reg);
    assign neg_w     = sat_sum(-ext(w_reg));
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    assign y_next    = sat_sum(ext(x_reg) + ext(h_reg >>> 1));
    assign sample_out = y_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_C_W2:    begin op_a = coef_c_reg;   op_b = w2_reg;   end
            MUL_D_OMC:   begin op_a = coef_d_reg;   op_b = omc_reg;  end
            MUL_K_W1:    begin op_a = k_reg;        op_b = w1_reg;   end
            MUL_C_NEGW:  begin op_a = coef_c_reg;   op_b = neg_w;    end
            MUL_H0_DIFF: begin op_a = peak_gm1_reg; op_b = diff_reg; end
            default:     begin op_a = coef_c_reg;   op_b = w2_reg;   end
        endcase
    end

    always_comb
    begin
        unique case (cmd.alu_op)
            ALU_OMC:  alu_res = sat_sum(UNITY - ext(coef_c_reg));
            ALU_W:    alu_res = sat_sum(ext(x_reg) - ext(t1_reg) + ext(t2_reg));
            ALU_A:    alu_res = sat_sum(ext(m_reg) + ext(t1_reg) + ext(w2_reg));
            ALU_DIFF: alu_res = sat_sum(ext(x_reg) - ext(a_reg));
            default:  alu_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_c_reg   <= '0;
            coef_d_reg   <= '0;
            peak_gm1_reg <= '0;
            w1_reg       <= '0;
            w2_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_COEF_C:   coef_c_reg   <= cfg_data;
                    REG_COEF_D:   coef_d_reg   <= cfg_data;
                    REG_PEAK_GM1: peak_gm1_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.commit)
            begin
                w2_reg <= w1_reg;
                w1_reg <= w_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= sample_in;
        if (cmd.mul_en)
            prod_reg <= prod_next;
        unique case (cmd.mq_dst)
            MQ_T2:   t2_reg <= mq;
            MQ_K:    k_reg  <= mq;
            MQ_T1:   t1_reg <= mq;
            MQ_M:    m_reg  <= mq;
            MQ_H:    h_reg  <= mq;
            default: ;
        endcase
        unique case (cmd.alu_op)
            ALU_OMC:  omc_reg  <= alu_res;
            ALU_W:    w_reg    <= alu_res;
            ALU_A:    a_reg    <= alu_res;
            ALU_DIFF: diff_reg <= alu_res;
            default:  ;
        endcase
        if (cmd.commit)
            y_reg <= y_next;
    end

endmodule

// ===== rtl/apeq_checker.sv =====
// Port-level checker for allpass_peak_eq_filter, attached by bind.
// No dependencies beyond the top-level port list.
module apeq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // one sample at a time: busy right after an input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // a fresh result is only produced by the busy sequencer
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

    // reset leaves no result pending in the following cycle
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind allpass_peak_eq_filter apeq_checker u_apeq_checker (.*);

// ===== tb/sv/tb_allpass_peak_eq_filter.sv =====
// Self-checking testbench for allpass_peak_eq_filter: a bit-exact predictor of the
// peak equalizer section checks every output sample under bursty input and stalls.
// Depends on apeq_pkg and the allpass_peak_eq_filter RTL.
module tb_allpass_peak_eq_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import apeq_pkg::*;

    localparam int          LIMIT_CYCLES  = 1000000;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          LONG_HOLD     = 600;
    localparam int          RAND_PHASES   = 12;
    localparam int          PHASE_ITEMS   = 130;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;
    localparam logic [31:0] S_MAX         = 32'h7fffffff;
    localparam logic [31:0] S_MIN         = 32'h80000000;
    localparam longint      Q_MAX         = 64'sd2147483647;
    localparam longint      Q_MIN         = -64'sd2147483648;
    localparam longint      ONE_Q         = longint'(1) << MQ_SHIFT;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Predictor state: coefficients and the two allpass delays
    longint coef_c_q  = 0;
    longint coef_d_q  = 0;
    longint coef_h0_q = 0;
    longint ap_w1     = 0;
    longint ap_w2     = 0;

    logic [31:0] pending_samples[$];
    logic [31:0] expected_out[$];

    int  errors      = 0;
    int  checked     = 0;
    int  cycles      = 0;
    int  cfg_count   = 0;
    int  settings    = 0;
    int  hold_req    = 0;
    int  hold_seen   = 0;
    int  hold_left   = 0;
    int  rx_mode     = 0;
    int  rx_left     = 0;
    int  gap_left    = 0;
    int  burst_left  = 0;
    bit  in_fire     = 1'b0;

    always #1 clk = ~clk;

    allpass_peak_eq_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [31:0] sample_in
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [31:0] sample_out
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic longint clamp32(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // Full product, floor shift back to Q format, saturate
    function automatic longint qmul(input longint p, input longint q);
        longint prod;
        prod = p * q;
        return clamp32(prod >>> MQ_SHIFT);
    endfunction

    // One step of the equalizer; advances the allpass delay line
    function automatic logic [31:0] equalize_sample(input logic [31:0] raw);
        longint x, k, t1, t2, w, a, diff, h, y;
        x    = longint'($signed(raw));
        k    = qmul(coef_d_q, clamp32(ONE_Q - coef_c_q));
        t1   = qmul(k, ap_w1);
        t2   = qmul(coef_c_q, ap_w2);
        w    = clamp32(x - t1 + t2);
        a    = clamp32(qmul(coef_c_q, clamp32(-w)) + t1 + ap_w2);
        ap_w2 = ap_w1;
        ap_w1 = w;
        diff = clamp32(x - a);
        h    = qmul(coef_h0_q, diff);
        y    = clamp32(x + (h >>> 1));
        return y[31:0];
    endfunction

    function automatic logic [31:0] rand_coef();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = S_MAX;
                    2:       v = S_MIN;
                    3:       v = 32'(ONE_Q);
                    default: v = 32'(-ONE_Q);
                endcase
            end
            1:       v = $urandom;
            default: v = 32'(longint'($urandom_range(0, 32'(4 * ONE_Q))) - 2 * ONE_Q);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_sample();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6, 7: v = 32'(longint'($urandom_range(0, 32'h01ff_ffff)) - 64'sh0100_0000);
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = S_MAX;
                    1:       v = S_MIN;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 32'd1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_samples.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24);
                end
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches mode every so often; long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_left % 16) < 5);
            endcase
        end
    end

    // Monitor: prediction on accepted inputs and writes, checking on accepted outputs
    always @(posedge clk)
    begin
        logic [31:0] want;
        cycles++;
        in_fire = 1'b0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected sample_out transaction, actual %0d", $signed(m_tdata));
                    errors++;
                end
                else begin
                    want = expected_out.pop_front();
                    checked++;
                    if (m_tdata !== want) begin
                        $error("sample_out mismatch: expected %0d actual %0d",
                               $signed(want), $signed(m_tdata));
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_fire = 1'b1;
                expected_out.push_back(equalize_sample(s_tdata));
            end
            if (cfg_valid && cfg_ready) begin
                cfg_count++;
                case (cfg_index)
                    REG_COEF_C:   coef_c_q  = longint'($signed(cfg_data));
                    REG_COEF_D:   coef_d_q  = longint'($signed(cfg_data));
                    REG_PEAK_GM1: coef_h0_q = longint'($signed(cfg_data));
                    default:      ;
                endcase
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Called at a falling edge with the block idle
    task automatic program_coefs(input logic [31:0] c, input logic [31:0] d,
                                 input logic [31:0] h0, input bit junk);
        logic [1:0]  idx[4];
        logic [31:0] val[4];
        int          n;
        int          seen;
        idx[0] = REG_COEF_C;   val[0] = c;
        idx[1] = REG_COEF_D;   val[1] = d;
        idx[2] = REG_PEAK_GM1; val[2] = h0;
        idx[3] = REG_UNUSED;   val[3] = $urandom;
        n = junk ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            seen = cfg_count;
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(negedge clk); while (cfg_count == seen);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] edge_vals[8];
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients: pass-through, field extremes
        pending_samples = '{32'd0, 32'd1, '1, S_MAX, S_MIN, 32'h5555_5555, 32'haaaa_aaaa};
        wait_idle();

        // Extreme coefficients drive sums and products into saturation;
        // the write to the unused index must change nothing
        program_coefs(S_MAX, S_MIN, S_MAX, 1'b1);
        edge_vals = '{S_MAX, S_MAX, S_MIN, S_MIN, 32'd0, '1, 32'd1, S_MAX};
        foreach (edge_vals[i])
            pending_samples.push_back(edge_vals[i]);
        wait_idle();

        // Realistic boost section, impulse response incl. negative halving
        program_coefs(32'd120795955, 32'(-64'sd67108864), 32'd268435456, 1'b0);
        pending_samples = '{32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            32'hc000_0000, 32'd0};
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0)
                program_coefs(S_MIN, S_MAX, S_MIN, 1'b0);
            else
                program_coefs(rand_coef(), rand_coef(), rand_coef(), 1'($urandom_range(0, 1)));
            // One phase keeps the output blocked while the input keeps coming
            if (p == 3)
                hold_req++;
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_samples.push_back(rand_sample());
            wait_idle();
        end

        $display("Checked %0d equalized samples over %0d coefficient settings,",
                 checked, settings);
        $display("with bursty input, output stalls and %0d long output hold-off(s).", hold_req);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/apeq_pkg.sv
rtl/apeq_ctrl.sv
rtl/apeq_datapath.sv
rtl/allpass_peak_eq_filter.sv
rtl/apeq_checker.sv
tb/sv/tb_allpass_peak_eq_filter.sv
